/* sv/nearest_neighbor_image_scaler_assert.svh */
// Assertion macros used by the checker file of the image scaler.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_ASSERT_SVH

// Checked at every clock edge outside reset.
`define NNIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define NNIS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/nnis_pkg.sv */
// Package of constants, types and helpers for the image scaler.
package nnis_pkg;

  localparam int MAX_SIDE    = 64;
  localparam int SIZE_W      = 7;
  localparam int PIX_W       = 32;
  localparam int IDX_W       = 12;
  localparam int COORD_W     = 6;
  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int QUO_W       = $clog2(MAX_SIDE);
  localparam int CNT_W       = (QUO_W > 1) ? $clog2(QUO_W) : 1;
  localparam int PROD_W      = COORD_W + SIZE_W;
  localparam int AREA_W      = 2 * SIZE_W;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_DST_WIDTH,
    REG_DST_HEIGHT
  } reg_idx_t;

  // A size of zero counts as one, and anything above the largest side as that side.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_W'(MAX_SIDE)) begin
      r = SIZE_W'(MAX_SIDE);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* sv/nearest_neighbor_image_scaler.sv */
// Nearest-neighbour image scaler: source pixel store, coordinate mapping and control.
//
// Items arrive on the in_ channel (valid/ready). An item with in_func low loads
// in_src_pixel at raster index in_src_index and gives no result.
// An index at or beyond the source area is dropped. An item with in_func high reads
// destination pixel (in_dst_x, in_dst_y) and gives one result on the out_ channel:
// the nearest source pixel, or zero with out_coord_error set when the coordinate lies
// outside the destination size.
// A read in range maps both coordinates at once in the six-step restoring divider,
// then reads the pixel store; the next item is taken once the result has gone into
// the output register. A read outside the destination size skips both. Loads are
// taken every cycle while no read is in progress.
// The result sits in an output register, so loads keep flowing while the receiver
// stalls; a read waits in its last step until the output register is free.
// The sizes are set over the APB port at addresses 0, 4, 8 and 12 and return to 16
// at reset. Reset clears the control state; the pixel store is not cleared and must
// be loaded before it is read.
module nearest_neighbor_image_scaler import nnis_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [IDX_W-1:0]   in_src_index,
  input  logic [PIX_W-1:0]   in_src_pixel,
  input  logic [COORD_W-1:0] in_dst_x,
  input  logic [COORD_W-1:0] in_dst_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_pixel,
  output logic               out_coord_error,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [PROD_W-1:0] rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt;
  logic [QUO_W-1:0]  quo_x_r, quo_x_nxt, quo_y_r, quo_y_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_pixel_r, out_pixel_nxt;
  logic              out_err_r, out_err_nxt;

  logic [SIZE_W-1:0] sw, sh, dw, dh;
  logic [AREA_W-1:0] area;
  logic              in_fire, load_we, coord_err, cnt_last, out_free;
  logic              div_en, ram_re, out_load;
  logic [PROD_W-1:0] prod_x, prod_y, shift_x, shift_y;
  logic              ge_x, ge_y;
  logic [PROD_W:0]   lin_idx;
  logic [PIX_W-1:0]  ram_rdata;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign sw   = eff_size(src_w_r);
  assign sh   = eff_size(src_h_r);
  assign dw   = eff_size(dst_w_r);
  assign dh   = eff_size(dst_h_r);
  assign area = AREA_W'(sw) * AREA_W'(sh);

  assign in_fire   = in_valid && in_ready;
  assign load_we   = in_fire && !in_func && (AREA_W'(in_src_index) < area);
  assign coord_err = (SIZE_W'(in_dst_x) >= dw) || (SIZE_W'(in_dst_y) >= dh);
  assign prod_x    = PROD_W'(in_dst_x) * PROD_W'(sw);
  assign prod_y    = PROD_W'(in_dst_y) * PROD_W'(sh);
  assign cnt_last  = (cnt_r == '0);
  assign out_free  = !out_valid_r || out_ready;

  assign shift_x = PROD_W'(dw) << cnt_r;
  assign shift_y = PROD_W'(dh) << cnt_r;
  assign ge_x    = (rem_x_r >= shift_x);
  assign ge_y    = (rem_y_r >= shift_y);
  assign lin_idx = (PROD_W+1)'(quo_y_r) * (PROD_W+1)'(sw) + (PROD_W+1)'(quo_x_r);

  nnis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (STORE_AW'(in_src_index)),
    .wdata (in_src_pixel),
    .re    (ram_re),
    .raddr (lin_idx[STORE_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_func) begin
          state_nxt = coord_err ? ST_RESP : ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_last) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    div_en   = 1'b0;
    ram_re   = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_DIV:  div_en   = 1'b1;
      ST_READ: ram_re   = 1'b1;
      ST_RESP: out_load = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  always_comb begin
    rem_x_nxt = rem_x_r;
    rem_y_nxt = rem_y_r;
    quo_x_nxt = quo_x_r;
    quo_y_nxt = quo_y_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    if (in_fire && in_func) begin
      rem_x_nxt = prod_x;
      rem_y_nxt = prod_y;
      quo_x_nxt = '0;
      quo_y_nxt = '0;
      cnt_nxt   = CNT_W'(QUO_W - 1);
      err_nxt   = coord_err;
    end else if (div_en) begin
      rem_x_nxt = ge_x ? rem_x_r - shift_x : rem_x_r;
      rem_y_nxt = ge_y ? rem_y_r - shift_y : rem_y_r;
      quo_x_nxt = {quo_x_r[QUO_W-2:0], ge_x};
      quo_y_nxt = {quo_y_r[QUO_W-2:0], ge_y};
      cnt_nxt   = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
    out_pixel_nxt = out_pixel_r;
    out_err_nxt   = out_err_r;
    if (out_load) begin
      out_pixel_nxt = err_r ? '0 : ram_rdata;
      out_err_nxt   = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_x_r     <= rem_x_nxt;
    rem_y_r     <= rem_y_nxt;
    quo_x_r     <= quo_x_nxt;
    quo_y_r     <= quo_y_nxt;
    cnt_r       <= cnt_nxt;
    err_r       <= err_nxt;
    out_pixel_r <= out_pixel_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= SIZE_W'(16);
      src_h_r <= SIZE_W'(16);
      dst_w_r <= SIZE_W'(16);
      dst_h_r <= SIZE_W'(16);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SRC_WIDTH:  src_w_r <= pwdata[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_h_r <= pwdata[SIZE_W-1:0];
        REG_DST_WIDTH:  dst_w_r <= pwdata[SIZE_W-1:0];
        REG_DST_HEIGHT: dst_h_r <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SRC_WIDTH:  prdata = PDATA_W'(src_w_r);
      REG_SRC_HEIGHT: prdata = PDATA_W'(src_h_r);
      REG_DST_WIDTH:  prdata = PDATA_W'(dst_w_r);
      REG_DST_HEIGHT: prdata = PDATA_W'(dst_h_r);
      default:        prdata = '0;
    endcase
  end

  assign pready          = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_pixel       = out_pixel_r;
  assign out_coord_error = out_err_r;

endmodule

/* sv/nnis_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module nnis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/nnis_checker.sv */
// Port-level checker for the image scaler, bound to the top level.
`include "nearest_neighbor_image_scaler_assert.svh"

module nnis_checker import nnis_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_func,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_pixel,
  input logic             out_coord_error
);

  logic             out_stall;
  logic             err_shown;
  logic             read_take;
  logic [PIX_W+1:0] out_word;

  assign out_stall = out_valid && !out_ready;
  assign err_shown = out_valid && out_coord_error;
  assign read_take = in_valid && in_ready && in_func;
  assign out_word  = {out_valid, out_pixel, out_coord_error};

  `NNIS_ASSERT(a_out_hold, out_stall |=> $stable(out_word), "stalled result changed")
  `NNIS_ASSERT(a_err_zero, err_shown |-> out_pixel == '0, "error result carries a pixel")
  `NNIS_ASSERT(a_read_busy, read_take |=> !in_ready, "item taken during a read")
  `NNIS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result shown after reset")

endmodule

bind nearest_neighbor_image_scaler nnis_checker u_nnis_checker (.*);

/* sim/nearest_neighbor_image_scaler_tb.sv */
// Self-checking testbench for the nearest-neighbour image scaler with directed and random items.
`timescale 1ns / 100ps

module nearest_neighbor_image_scaler_tb;
  import nnis_pkg::*;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_READ    = 1'b1;
  localparam int   IDLE_PCT     = 36;
  localparam int   STALL_LIMIT  = 2000;
  localparam int   DRAIN_CYCLES = 12;
  localparam int   REPORT_LIMIT = 10;
  localparam int   RANDOM_ITEMS = 1100;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             coord_error;
  } scaled_pixel_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_func;
  logic [IDX_W-1:0]   in_src_index;
  logic [PIX_W-1:0]   in_src_pixel;
  logic [COORD_W-1:0] in_dst_x;
  logic [COORD_W-1:0] in_dst_y;
  logic               out_valid;
  logic               out_ready;
  logic [PIX_W-1:0]   out_pixel;
  logic               out_coord_error;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic [SIZE_W-1:0]  size_reg [4];
  logic [PIX_W-1:0]   pixel_store [STORE_DEPTH];
  bit                 pixel_loaded [STORE_DEPTH];
  scaled_pixel_t      expected_pixels [$];
  int                 mismatch_count;
  int                 hold_cycles;
  int                 useful_items;
  bit                 calm;

  nearest_neighbor_image_scaler uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_src_index    (in_src_index),
    .in_src_pixel    (in_src_pixel),
    .in_dst_x        (in_dst_x),
    .in_dst_y        (in_dst_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel       (out_pixel),
    .out_coord_error (out_coord_error),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int clamp_side(input logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic int source_area();
    return clamp_side(size_reg[REG_SRC_WIDTH]) * clamp_side(size_reg[REG_SRC_HEIGHT]);
  endfunction

  function automatic bit map_to_source(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                       output int idx);
    int sw, sh, dw, dh;
    sw  = clamp_side(size_reg[REG_SRC_WIDTH]);
    sh  = clamp_side(size_reg[REG_SRC_HEIGHT]);
    dw  = clamp_side(size_reg[REG_DST_WIDTH]);
    dh  = clamp_side(size_reg[REG_DST_HEIGHT]);
    idx = 0;
    if (int'(x) >= dw || int'(y) >= dh) return 1'b0;
    idx = ((int'(y) * sh) / dh) * sw + (int'(x) * sw) / dw;
    return 1'b1;
  endfunction

  // Returns whether the item had any effect on the block.
  function automatic bit scale_item(input logic func, input logic [IDX_W-1:0] index,
                                    input logic [PIX_W-1:0] pix, input logic [COORD_W-1:0] x,
                                    input logic [COORD_W-1:0] y);
    int            idx;
    scaled_pixel_t r;
    if (func == FUNC_LOAD) begin
      if (int'(index) >= source_area()) return 1'b0;
      pixel_store[index]  = pix;
      pixel_loaded[index] = 1'b1;
      return 1'b1;
    end
    r.pixel       = '0;
    r.coord_error = 1'b1;
    if (map_to_source(x, y, idx)) begin
      r.pixel       = pixel_store[idx];
      r.coord_error = 1'b0;
    end
    expected_pixels.push_back(r);
    return 1'b1;
  endfunction

  function automatic void note_mismatch(input string what, input logic [PIX_W-1:0] want,
                                        input logic [PIX_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s: expected %h, got %h", $time, what, want, got);
  endfunction

  task automatic send_item(input logic func, input logic [IDX_W-1:0] index,
                           input logic [PIX_W-1:0] pix, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y);
    bit rdy;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid     <= 1'b1;
    in_func      <= func;
    in_src_index <= index;
    in_src_pixel <= pix;
    in_dst_x     <= x;
    in_dst_y     <= y;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    if (scale_item(func, index, pix, x, y)) useful_items++;
  endtask

  task automatic load_at(input logic [IDX_W-1:0] index, input logic [PIX_W-1:0] pix);
    send_item(FUNC_LOAD, index, pix, COORD_W'($urandom), COORD_W'($urandom));
  endtask

  // A read that maps onto a pixel never loaded gets that pixel loaded first.
  task automatic read_at(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int idx;
    if (map_to_source(x, y, idx) && !pixel_loaded[idx]) load_at(IDX_W'(idx), $urandom);
    send_item(FUNC_READ, IDX_W'($urandom), $urandom, x, y);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input reg_idx_t r, input logic [PDATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(r));
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    size_reg[r] = v[SIZE_W-1:0];
    @(posedge clk);
  endtask

  task automatic check_sizes();
    logic [PDATA_W-1:0] got;
    for (int i = 0; i < 4; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= PADDR_W'(4 * i);
      @(posedge clk);
      penable <= 1'b1;
      @(negedge clk);
      got = prdata;
      @(posedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
      if (got !== PDATA_W'(size_reg[i])) note_mismatch("size register", PDATA_W'(size_reg[i]), got);
    end
  endtask

  task automatic configure(input logic [PDATA_W-1:0] sw, input logic [PDATA_W-1:0] sh,
                           input logic [PDATA_W-1:0] dw, input logic [PDATA_W-1:0] dh);
    settle();
    write_size(REG_SRC_WIDTH, sw);
    write_size(REG_SRC_HEIGHT, sh);
    write_size(REG_DST_WIDTH, dw);
    write_size(REG_DST_HEIGHT, dh);
    check_sizes();
  endtask

  // Loads a whole source image in raster order, then reads every destination pixel.
  task automatic scan_frame(input logic [PDATA_W-1:0] sw, input logic [PDATA_W-1:0] sh,
                            input logic [PDATA_W-1:0] dw, input logic [PDATA_W-1:0] dh);
    configure(sw, sh, dw, dh);
    for (int i = 0; i < source_area(); i++) load_at(IDX_W'(i), $urandom);
    for (int y = 0; y < clamp_side(size_reg[REG_DST_HEIGHT]); y++)
      for (int x = 0; x < clamp_side(size_reg[REG_DST_WIDTH]); x++)
        read_at(COORD_W'(x), COORD_W'(y));
  endtask

  function automatic logic [PDATA_W-1:0] random_size();
    if ($urandom_range(9) == 0) return PDATA_W'($urandom_range(1) ? 0 : $urandom_range(127, 65));
    return PDATA_W'($urandom_range(64, 1));
  endfunction

  task automatic random_burst(input int count);
    int dw, dh;
    dw = clamp_side(size_reg[REG_DST_WIDTH]);
    dh = clamp_side(size_reg[REG_DST_HEIGHT]);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 45) begin
        if ($urandom_range(9) == 0) load_at(IDX_W'($urandom), $urandom);
        else load_at(IDX_W'($urandom_range(source_area() - 1)), $urandom);
      end else if ($urandom_range(9) < 8) begin
        read_at(COORD_W'($urandom_range(dw - 1)), COORD_W'($urandom_range(dh - 1)));
      end else begin
        read_at(COORD_W'($urandom), COORD_W'($urandom));
      end
    end
  endtask

  task automatic test_reset_sizes();
    check_sizes();
  endtask

  task automatic test_directed_items();
    load_at(IDX_W'(0), 32'h0000_0000);
    load_at(IDX_W'(255), 32'hFFFF_FFFF);
    load_at(IDX_W'(256), 32'hDEAD_BEEF);
    load_at(IDX_W'(4095), 32'h5A5A_A5A5);
    read_at(COORD_W'(0), COORD_W'(0));
    read_at(COORD_W'(15), COORD_W'(15));
    read_at(COORD_W'(16), COORD_W'(0));
    read_at(COORD_W'(0), COORD_W'(16));
    read_at(COORD_W'(63), COORD_W'(63));
    read_at(COORD_W'(7), COORD_W'(9));
  endtask

  task automatic test_size_extremes();
    configure(64, 64, 64, 64);
    load_at(IDX_W'(4095), 32'hFFFF_FFFF);
    read_at(COORD_W'(63), COORD_W'(63));
    configure(64, 64, 1, 1);
    read_at(COORD_W'(0), COORD_W'(0));
    read_at(COORD_W'(1), COORD_W'(0));
    configure(1, 1, 64, 64);
    load_at(IDX_W'(1), $urandom);
    read_at(COORD_W'(63), COORD_W'(0));
    read_at(COORD_W'(31), COORD_W'(63));
    // Zero counts as one and oversized values as the largest side; upper data bits are dropped.
    configure(0, 127, 65, 32'hFFFF_FF81);
    load_at(IDX_W'(64), $urandom);
    load_at(IDX_W'(63), $urandom);
    read_at(COORD_W'(63), COORD_W'(0));
    read_at(COORD_W'(10), COORD_W'(1));
  endtask

  task automatic test_frame_scan();
    scan_frame(5, 3, 7, 4);
    scan_frame(12, 9, 4, 3);
  endtask

  task automatic test_result_backpressure();
    configure(16, 16, 16, 16);
    calm        = 1'b1;
    hold_cycles = 300;
    random_burst(40);
    calm = 1'b0;
    settle();
  endtask

  task automatic test_random_items();
    useful_items = 0;
    for (int phase = 0; useful_items < RANDOM_ITEMS; phase++) begin
      calm = (phase == 3);
      if (phase % 3 == 2) begin
        scan_frame(PDATA_W'($urandom_range(16, 1)), PDATA_W'($urandom_range(16, 1)),
                   PDATA_W'($urandom_range(16, 1)), PDATA_W'($urandom_range(16, 1)));
      end else begin
        configure(random_size(), random_size(), random_size(), random_size());
        random_burst(200);
      end
    end
    calm = 1'b0;
  endtask

  initial begin : result_checker
    logic          vld;
    scaled_pixel_t got;
    scaled_pixel_t want;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      vld             = out_valid && rst_n;
      got.pixel       = out_pixel;
      got.coord_error = out_coord_error;
      @(posedge clk);
      if (vld && out_ready) begin
        if (expected_pixels.size() == 0) begin
          note_mismatch("result with nothing expected", '0, got.pixel);
        end else begin
          want = expected_pixels.pop_front();
          if (got.pixel !== want.pixel) note_mismatch("pixel", want.pixel, got.pixel);
          if (got.coord_error !== want.coord_error)
            note_mismatch("coord_error", PIX_W'(want.coord_error), PIX_W'(got.coord_error));
        end
      end
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stall_watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_func      <= FUNC_LOAD;
    in_src_index <= '0;
    in_src_pixel <= '0;
    in_dst_x     <= '0;
    in_dst_y     <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    calm           = 1'b0;
    hold_cycles    = 0;
    mismatch_count = 0;
    useful_items   = 0;
    for (int i = 0; i < 4; i++) size_reg[i] = SIZE_W'(16);
    for (int i = 0; i < STORE_DEPTH; i++) pixel_loaded[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_sizes();
    test_directed_items();
    test_size_extremes();
    test_frame_scan();
    test_result_backpressure();
    test_random_items();
    settle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/nnis_pkg.sv
sv/nnis_ram.sv
sv/nearest_neighbor_image_scaler.sv
sv/nnis_checker.sv
sim/nearest_neighbor_image_scaler_tb.sv
